FILE: hdl/sdt_pkg.sv
// Shared types and constants for the stride detection table.
`default_nettype none
package sdt_pkg;
	localparam int unsigned SET_COUNT_DEF = 256;
	localparam int unsigned WAYS_DEF      = 4;
	localparam logic [63:0] SHARED_BIT    = 64'h0000_0000_0800_0000;
	localparam int unsigned HASH_SHIFT    = 40;
	localparam logic [1:0]  CONF_MAX      = 2'd3;
	localparam int unsigned BIN_COUNT     = 7;
	localparam int unsigned TYPE_SLOTS    = 5;
	localparam int unsigned HIST_SLOTS    = 28;
	localparam int unsigned ENTRY_W       = 1 + 64 + 64 + 32 + 2 + 32;

	typedef enum logic [1:0] {
		CMD_REF      = 2'd0,
		CMD_RD_HIST  = 2'd1,
		CMD_RD_TYPE  = 2'd2,
		CMD_NONE     = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		OUT_HIT      = 2'd0,
		OUT_ALLOC    = 2'd1,
		OUT_OVERFLOW = 2'd2,
		OUT_READ     = 2'd3
	} outcome_t;

	typedef struct packed {
		logic        valid;
		logic [63:0] signature;
		logic [63:0] last_addr;
		logic [31:0] stride;
		logic [1:0]  confidence;
		logic [31:0] access_count;
	} entry_t;

	function automatic logic [2:0] bin_of(input logic [31:0] s);
		logic [2:0] b;
		if (s[31])
			b = 3'd0;
		else if (s == 32'd0)
			b = 3'd1;
		else if (s < 32'd32)
			b = 3'd2;
		else if (s < 32'd64)
			b = 3'd3;
		else if (s < 32'd128)
			b = 3'd4;
		else if (s <= 32'd256)
			b = 3'd5;
		else
			b = 3'd6;
		return b;
	endfunction
endpackage
`default_nettype wire

FILE: hdl/sdt_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module sdt_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

FILE: hdl/stride_detection_table_core.sv
// Stride detection table top level: set scan sequencer over a shared entry RAM.
// A counter read is registered on acceptance and passes through the output state, which raises the result valid.
// A reference reads and checks one way at a time (read state, then check state)
// through the single RAM port, then passes through the output state to the result.
// One request in flight at a time; the next is taken once the result is taken.
// After reset a clearing pass over all SET_COUNT*WAYS entries zeroes the valid bits;
// histogram and type counters clear at once.
`default_nettype none
module stride_detection_table_core #(
	parameter int unsigned SET_COUNT = sdt_pkg::SET_COUNT_DEF,
	parameter int unsigned WAYS      = sdt_pkg::WAYS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// command[1:0], thread_id[33:2], ref_type[36:34], instr_addr[68:37],
	// data_addr[132:69], counter_index[137:133], zero fill to 144
	input  wire logic [143:0] s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// outcome[1:0], entry_stride_out[33:2], confidence_out[35:34],
	// pattern_seen[36], stride_bin[39:37], access_count_out[71:40],
	// counter_value[103:72]
	output logic      [103:0] m_tdata
);
	localparam int unsigned SET_W   = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
	localparam int unsigned WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int unsigned DEPTH   = SET_COUNT * WAYS;
	localparam int unsigned ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_READ  = 5'b00100,
		ST_CHECK = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	state_t state_q;
	logic [2:0]  type_q;
	logic [63:0] sig_q, addr_q;
	logic [SET_W-1:0] set_q;
	logic [WAY_W:0]   way_q;
	logic [ADDR_W-1:0] clr_q;
	logic [31:0] hist_q [sdt_pkg::HIST_SLOTS];
	logic [31:0] tcnt_q [sdt_pkg::TYPE_SLOTS];
	logic [103:0] res_q;

	logic [1:0]  in_cmd;
	logic [31:0] in_tid, in_pc;
	logic [2:0]  in_type;
	logic [63:0] in_addr, in_sig, in_hash;
	logic [4:0]  in_idx;

	assign in_cmd  = s_tdata[1:0];
	assign in_tid  = s_tdata[33:2];
	assign in_type = s_tdata[36:34];
	assign in_pc   = s_tdata[68:37];
	assign in_addr = s_tdata[132:69];
	assign in_idx  = s_tdata[137:133];
	assign in_sig  = {in_tid, in_pc} | ((in_type > 3'd1) ? sdt_pkg::SHARED_BIT : 64'd0);
	assign in_hash = in_sig ^ (in_sig >> sdt_pkg::HASH_SHIFT);

	logic [ADDR_W-1:0] ram_addr;
	logic              ram_we;
	sdt_pkg::entry_t   ram_wdata, ram_rdata;
	logic [sdt_pkg::ENTRY_W-1:0] ram_rbits;

	logic [ADDR_W-1:0] cur_e;
	assign cur_e = ADDR_W'(set_q) * ADDR_W'(WAYS) + ADDR_W'(way_q[WAY_W-1:0]);
	assign ram_addr = (state_q == ST_CLEAR) ? clr_q : cur_e;

	sdt_ram #(.WIDTH(sdt_pkg::ENTRY_W), .DEPTH(DEPTH)) u_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rbits)
	);
	assign ram_rdata = sdt_pkg::entry_t'(ram_rbits);

	logic [31:0] ns;
	logic [1:0]  nconf;
	logic [2:0]  nbin;
	logic        match_s, seen;
	logic [31:0] ncnt;

	assign ns = addr_q[31:0] - ram_rdata.last_addr[31:0];
	assign match_s = (ns == ram_rdata.stride);
	assign nbin = sdt_pkg::bin_of(ns);
	assign ncnt = ram_rdata.access_count + 32'd1;
	always_comb begin
		if (match_s)
			nconf = (ram_rdata.confidence < sdt_pkg::CONF_MAX) ?
				ram_rdata.confidence + 2'd1 : ram_rdata.confidence;
		else
			nconf = (ram_rdata.confidence > 2'd0) ? ram_rdata.confidence - 2'd1 : 2'd0;
	end
	assign seen = match_s && (nconf >= 2'd2);

	always_comb begin
		ram_we = 1'b0;
		ram_wdata = ram_rdata;
		if (state_q == ST_CLEAR) begin
			ram_we = 1'b1;
			ram_wdata = '0;
		end else if (state_q == ST_CHECK && !ram_rdata.valid) begin
			ram_we = 1'b1;
			ram_wdata.valid = 1'b1;
			ram_wdata.signature = sig_q;
			ram_wdata.last_addr = addr_q;
			ram_wdata.stride = 32'd0;
			ram_wdata.confidence = 2'd0;
			ram_wdata.access_count = 32'd1;
		end else if (state_q == ST_CHECK && ram_rdata.signature == sig_q) begin
			ram_we = 1'b1;
			ram_wdata.last_addr = addr_q;
			ram_wdata.access_count = ncnt;
			ram_wdata.confidence = nconf;
			if (!match_s && nconf != 2'd2)
				ram_wdata.stride = ns;
		end
	end

	assign s_tready = (state_q == ST_IDLE) && !m_tvalid;
	assign m_tdata = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			m_tvalid <= 1'b0;
			clr_q <= '0;
			for (int i = 0; i < sdt_pkg::HIST_SLOTS; i++) hist_q[i] <= 32'd0;
			for (int i = 0; i < sdt_pkg::TYPE_SLOTS; i++) tcnt_q[i] <= 32'd0;
		end else begin
			if (m_tvalid && m_tready)
				m_tvalid <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == ADDR_W'(DEPTH - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (s_tvalid && s_tready) begin
						type_q <= in_type;
						sig_q <= in_sig;
						addr_q <= in_addr;
						set_q <= in_hash[SET_W-1:0] & SET_W'(SET_COUNT - 1);
						way_q <= '0;
						res_q <= '0;
						case (sdt_pkg::cmd_t'(in_cmd)) inside
							sdt_pkg::CMD_RD_HIST, sdt_pkg::CMD_RD_TYPE: begin
								res_q[1:0] <= sdt_pkg::OUT_READ;
								if (in_cmd == sdt_pkg::CMD_RD_HIST &&
								    in_idx < 5'(sdt_pkg::HIST_SLOTS))
									res_q[103:72] <= hist_q[in_idx];
								else if (in_cmd == sdt_pkg::CMD_RD_TYPE &&
								         in_idx < 5'(sdt_pkg::TYPE_SLOTS))
									res_q[103:72] <= tcnt_q[in_idx[2:0]];
								state_q <= ST_OUT;
							end
							sdt_pkg::CMD_REF: begin
								if (in_type < 3'd4)
									tcnt_q[in_type] <= tcnt_q[in_type] + 32'd1;
								else
									tcnt_q[4] <= tcnt_q[4] + 32'd1;
								state_q <= ST_READ;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_READ: begin
					if (way_q >= (WAY_W+1)'(WAYS)) begin
						res_q[1:0] <= sdt_pkg::OUT_OVERFLOW;
						state_q <= ST_OUT;
					end else
						state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (!ram_rdata.valid) begin
						res_q[1:0] <= sdt_pkg::OUT_ALLOC;
						res_q[39:37] <= 3'd1;
						res_q[71:40] <= 32'd1;
						state_q <= ST_OUT;
					end else if (ram_rdata.signature == sig_q) begin
						res_q[1:0] <= sdt_pkg::OUT_HIT;
						res_q[33:2] <= ns;
						res_q[35:34] <= nconf;
						res_q[36] <= seen;
						res_q[39:37] <= nbin;
						res_q[71:40] <= ncnt;
						if (seen && type_q < 3'd4)
							hist_q[5'(type_q) * 5'(sdt_pkg::BIN_COUNT) + 5'(nbin)] <=
								hist_q[5'(type_q) * 5'(sdt_pkg::BIN_COUNT) + 5'(nbin)] + 32'd1;
						state_q <= ST_OUT;
					end else begin
						way_q <= way_q + 1'b1;
						state_q <= ST_READ;
					end
				end
				ST_OUT: begin
					m_tvalid <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: dv/stride_detection_table_core_checker.sv
// Checker for the stride detection table: predicts results from accepted requests and compares.
module stride_detection_table_core_checker (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	input  wire logic         s_tready,
	input  wire logic [143:0] s_tdata,
	input  wire logic         m_tvalid,
	input  wire logic         m_tready,
	input  wire logic [103:0] m_tdata,
	output int                fail_count,
	output int                pending,
	output int                hits_seen,
	output int                allocs_seen,
	output int                overflows_seen,
	output int                reads_seen,
	output int                patterns_seen
);
	import sdt_pkg::*;

	localparam int SETS = SET_COUNT_DEF;
	localparam int NWAYS = WAYS_DEF;
	localparam int E_W = $clog2(SETS * NWAYS);

	typedef struct packed {
		logic [31:0] counter_value;
		logic [31:0] access_count;
		logic [2:0]  bin;
		logic        pattern;
		logic [1:0]  confidence;
		logic [31:0] stride;
		outcome_t    outcome;
	} result_t;

	bit          valid_tbl [SETS*NWAYS];
	logic [63:0] sig_tbl   [SETS*NWAYS];
	logic [63:0] addr_tbl  [SETS*NWAYS];
	logic [31:0] stride_tbl[SETS*NWAYS];
	logic [1:0]  conf_tbl  [SETS*NWAYS];
	logic [31:0] count_tbl [SETS*NWAYS];
	logic [31:0] hist_cnt  [HIST_SLOTS];
	logic [31:0] type_cnt  [TYPE_SLOTS];
	result_t     expected_results[$];

	function automatic logic [2:0] stride_class(input logic [31:0] s);
		if (s[31]) return 3'd0;
		if (s == 0) return 3'd1;
		if (s < 32) return 3'd2;
		if (s < 64) return 3'd3;
		if (s < 128) return 3'd4;
		if (s <= 256) return 3'd5;
		return 3'd6;
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	task automatic predict_table(input logic [143:0] d);
		cmd_t        cmd;
		logic [31:0] tid, pc, ns;
		logic [2:0]  rtype, bin;
		logic [63:0] addr, sig, h;
		logic [4:0]  idx;
		logic [1:0]  conf;
		int          set;
		logic [E_W-1:0] e;
		bit          done;
		result_t     r;
		cmd = cmd_t'(d[1:0]);
		tid = d[33:2];
		rtype = d[36:34];
		pc = d[68:37];
		addr = d[132:69];
		idx = d[137:133];
		r = '0;
		if (cmd == CMD_NONE) return;
		if (cmd != CMD_REF) begin
			r.outcome = OUT_READ;
			if (cmd == CMD_RD_HIST && idx < HIST_SLOTS) r.counter_value = hist_cnt[idx];
			if (cmd == CMD_RD_TYPE && idx < TYPE_SLOTS) r.counter_value = type_cnt[idx[2:0]];
			expected_results.push_back(r);
			return;
		end
		type_cnt[rtype < 3'd4 ? rtype : 3'd4]++;
		sig = {tid, pc} | (rtype > 1 ? SHARED_BIT : 64'd0);
		h = sig ^ (sig >> HASH_SHIFT);
		set = int'(h & (SETS - 1));
		r.outcome = OUT_OVERFLOW;
		done = 0;
		for (int w = 0; w < NWAYS && !done; w++) begin
			e = E_W'(set * NWAYS + w);
			if (!valid_tbl[e]) begin
				valid_tbl[e] = 1;
				sig_tbl[e] = sig;
				addr_tbl[e] = addr;
				stride_tbl[e] = 0;
				conf_tbl[e] = 0;
				count_tbl[e] = 1;
				r.outcome = OUT_ALLOC;
				r.bin = 1;
				r.access_count = 1;
				done = 1;
			end else if (sig_tbl[e] == sig) begin
				ns = addr[31:0] - addr_tbl[e][31:0];
				conf = conf_tbl[e];
				bin = stride_class(ns);
				count_tbl[e]++;
				addr_tbl[e] = addr;
				if (ns == stride_tbl[e]) begin
					if (conf < CONF_MAX) conf++;
					if (conf >= 2) begin
						r.pattern = 1;
						if (rtype < 4) hist_cnt[5'(rtype * BIN_COUNT + bin)]++;
					end
				end else begin
					if (conf > 0) conf--;
					if (conf != 2) stride_tbl[e] = ns;
				end
				conf_tbl[e] = conf;
				r.outcome = OUT_HIT;
				r.stride = ns;
				r.confidence = conf;
				r.bin = bin;
				r.access_count = count_tbl[e];
				done = 1;
			end
		end
		expected_results.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want, got;
		if (!arst_n) begin
			foreach (valid_tbl[i]) valid_tbl[i] = 0;
			foreach (hist_cnt[i]) hist_cnt[i] = 0;
			foreach (type_cnt[i]) type_cnt[i] = 0;
			expected_results.delete();
			fail_count = 0;
			hits_seen = 0;
			allocs_seen = 0;
			overflows_seen = 0;
			reads_seen = 0;
			patterns_seen = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = result_t'(m_tdata);
				if (expected_results.size() == 0) begin
					$display("unexpected result %h at %0t", m_tdata, $realtime);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					if (got.outcome != want.outcome)
						report("outcome", 32'(got.outcome), 32'(want.outcome));
					if (got.stride != want.stride) report("stride", got.stride, want.stride);
					if (got.confidence != want.confidence)
						report("confidence", 32'(got.confidence), 32'(want.confidence));
					if (got.pattern != want.pattern)
						report("pattern", 32'(got.pattern), 32'(want.pattern));
					if (got.bin != want.bin) report("bin", 32'(got.bin), 32'(want.bin));
					if (got.access_count != want.access_count)
						report("count", got.access_count, want.access_count);
					if (got.counter_value != want.counter_value)
						report("counter", got.counter_value, want.counter_value);
					case (want.outcome)
						OUT_HIT: hits_seen++;
						OUT_ALLOC: allocs_seen++;
						OUT_OVERFLOW: overflows_seen++;
						default: reads_seen++;
					endcase
					if (want.pattern) patterns_seen++;
				end
			end
			if (s_tvalid && s_tready) predict_table(s_tdata);
		end
		pending = expected_results.size();
	end
endmodule

FILE: dv/stride_detection_table_core_tb.sv
// Testbench top for the stride detection table: stimulus, reset, watchdog and verdict.
module stride_detection_table_core_tb;
	import sdt_pkg::*;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [143:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [103:0] m_tdata;
	int           fail_count, pending;
	int           hits_seen, allocs_seen, overflows_seen, reads_seen, patterns_seen;
	int           idle_cycles;
	bit           stim_done;
	bit           hold_off;

	// per-stream state for well-formed strided sequences
	logic [31:0] stream_tid [16];
	logic [31:0] stream_pc  [16];
	logic [2:0]  stream_type[16];
	logic [63:0] stream_addr[16];
	logic [31:0] stream_step[16];

	stride_detection_table_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	stride_detection_table_core_checker chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.fail_count(fail_count), .pending(pending),
		.hits_seen(hits_seen), .allocs_seen(allocs_seen),
		.overflows_seen(overflows_seen), .reads_seen(reads_seen),
		.patterns_seen(patterns_seen)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	function automatic logic [143:0] pack_request(input cmd_t cmd, input logic [31:0] tid,
			input logic [2:0] rtype, input logic [31:0] pc, input logic [63:0] addr,
			input logic [4:0] idx);
		return {6'd0, idx, addr, pc, rtype, tid, cmd};
	endfunction

	task automatic send_request(input logic [143:0] d);
		int gap;
		gap = $urandom_range(0, 7);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= d;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_random_ref(input int n);
		logic [3:0] k;
		k = 4'($urandom_range(0, 15));
		case ($urandom_range(0, 9))
			0: send_request(pack_request(CMD_REF, $urandom, 3'($urandom), $urandom,
				{$urandom, $urandom}, 5'($urandom)));
			1: send_request(pack_request(cmd_t'($urandom_range(1, 3)), $urandom,
				3'($urandom), $urandom, {$urandom, $urandom}, 5'($urandom)));
			2: begin
				// break the stride of a stream
				stream_addr[k] = stream_addr[k] + {{32{1'b0}}, $urandom};
				send_request(pack_request(CMD_REF, stream_tid[k], stream_type[k],
					stream_pc[k], stream_addr[k], 5'($urandom)));
			end
			3: begin
				stream_tid[k] = $urandom_range(0, 3);
				stream_pc[k] = $urandom;
				stream_type[k] = 3'($urandom);
				stream_step[k] = (n % 3 == 0) ? $urandom : $urandom_range(0, 300) - 40;
			end
			default: begin
				stream_addr[k] = stream_addr[k] + {{32{stream_step[k][31]}}, stream_step[k]};
				send_request(pack_request(CMD_REF, stream_tid[k], stream_type[k],
					stream_pc[k], stream_addr[k], 5'($urandom)));
			end
		endcase
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		stim_done = 0;
		for (int k = 0; k < 16; k++) begin
			stream_tid[4'(k)] = 32'(k[1:0]);
			stream_pc[4'(k)] = $urandom;
			stream_type[4'(k)] = k[2:0];
			stream_addr[4'(k)] = {$urandom, $urandom};
			stream_step[4'(k)] = k * 24 - 64;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: counters at zero, field extremes, types 0-3 and 7, five stride bins
		send_request(pack_request(CMD_RD_HIST, 0, 3'd0, 0, 64'd0, 5'd0));
		send_request(pack_request(CMD_RD_TYPE, 0, 3'd0, 0, 64'd0, 5'd31));
		send_request(pack_request(CMD_NONE, 0, 3'd0, 0, 64'd0, 5'd0));
		send_request(pack_request(CMD_REF, '1, 3'd7, '1, '1, '1));
		send_request(pack_request(CMD_REF, '1, 3'd7, '1, 64'd5, '1));
		for (int t = 0; t < 4; t++)
			for (int j = 0; j < 4; j++)
				send_request(pack_request(CMD_REF, 32'd0, t[2:0], 32'h100,
					64'd1000 + 64'(j * (t == 0 ? -8 : t * 100)), 5'd0));
		// five signatures into set 0 forces an overflow
		for (int j = 0; j < 5; j++)
			send_request(pack_request(CMD_REF, 32'd0, 3'd0, j * 256, 64'd0, 5'd0));
		send_request(pack_request(CMD_RD_HIST, 0, 3'd0, 0, 64'd0, 5'd27));
		send_request(pack_request(CMD_RD_TYPE, 0, 3'd0, 0, 64'd0, 5'd4));
		send_request(pack_request(CMD_RD_HIST, 0, 3'd0, 0, 64'd0, 5'd28));
		for (int n = 0; n < 2000; n++) send_random_ref(n);
		for (int i = 0; i < 28; i++)
			send_request(pack_request(CMD_RD_HIST, 0, 3'd0, 0, 64'd0, 5'(i)));
		for (int i = 0; i < 5; i++)
			send_request(pack_request(CMD_RD_TYPE, 0, 3'd0, 0, 64'd0, 5'(i)));
		s_tvalid <= 1'b0;
		stim_done = 1;
	end

	// receiver: random stalls and long hold-offs
	initial begin
		int taken;
		m_tready = 1'b0;
		hold_off = 0;
		taken = 0;
		@(posedge arst_n);
		forever begin
			int gap;
			@(posedge clk);
			if (!hold_off && !stim_done &&
			    (taken == 100 || $urandom_range(0, 300) == 0)) begin
				hold_off = 1;
				m_tready <= 1'b0;
				repeat (60) @(posedge clk);
				hold_off = 0;
			end
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 7);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			taken++;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
	end

	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (idle_cycles > 5000) begin
				$display("stride_detection_table_core_tb: errors");
				$finish;
			end
			if (stim_done && pending == 0) begin
				repeat (20) @(posedge clk);
				$display("covered %0d hits, %0d allocations, %0d overflows, %0d reads",
					hits_seen, allocs_seen, overflows_seen, reads_seen);
				$display("stride patterns confirmed: %0d", patterns_seen);
				if (fail_count == 0 && pending == 0)
					$display("stride_detection_table_core_tb: clean");
				else
					$display("stride_detection_table_core_tb: errors");
				$finish;
			end
		end
	end
endmodule
